/* design/hhm_pkg.sv */
// package for the device heartbeat health monitor
// holds slot entry, result and config types, operation codes and constants
// no dependencies
package hhm_pkg;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned HEALTH_W = 12;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER  = 2'd0,
    OP_TICK      = 2'd1,
    OP_HEARTBEAT = 2'd2,
    OP_QUERY     = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEALTH_DEFAULT = 1'b0,
    CFG_HEALTH_MAX     = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  localparam logic [CFG_W-1:0] HEALTH_DEFAULT_RST = 11'd100;
  localparam logic [CFG_W-1:0] HEALTH_MAX_RST     = 11'd200;

  localparam logic signed [HEALTH_W:0]   HB_INC      = 13'sd50;
  localparam logic signed [HEALTH_W:0]   TICK_DEC    = 13'sd2;
  localparam logic signed [HEALTH_W-1:0] HEALTH_NONE = -12'sd1;

  typedef struct packed {
    logic [ID_W-1:0]            id;
    logic signed [HEALTH_W-1:0] health;
    logic                       online;
  } entry_t;

  typedef struct packed {
    logic [CFG_W-1:0] health_default;
    logic [CFG_W-1:0] health_max;
  } cfg_t;

  typedef struct packed {
    logic                       valid;
    logic                       found;
    logic                       online;
    logic signed [HEALTH_W-1:0] health;
  } res_t;

endpackage

/* design/hhm_if.sv */
// item channels of the heartbeat health monitor: command in, result out
// valid/ready handshake with source and sink modports
// depends on hhm_pkg
interface hhm_in_if;
  logic                        valid;
  logic                        ready;
  logic [hhm_pkg::OP_W-1:0]    operation;
  logic [hhm_pkg::SLOT_W-1:0]  slot;
  logic [hhm_pkg::ID_W-1:0]    device_id;

  modport source (output valid, output operation, output slot, output device_id,
                  input ready);
  modport sink   (input valid, input operation, input slot, input device_id,
                  output ready);
endinterface

interface hhm_out_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic                               online;
  logic signed [hhm_pkg::HEALTH_W-1:0] health;

  modport source (output valid, output found, output online, output health,
                  input ready);
  modport sink   (input valid, input found, input online, input health,
                  output ready);
endinterface

/* design/hhm_mem.sv */
// slot table memory: one write port, one registered read port
// per-entry valid bits cleared by reset, an unwritten entry reads as zero
// depends on hhm_pkg
module hhm_mem #(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned IW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [IW-1:0]   waddr_i,
  input  hhm_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [IW-1:0]   raddr_i,
  output hhm_pkg::entry_t rdata_o
);

  hhm_pkg::entry_t        mem_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   vld_q;
  hhm_pkg::entry_t        rd_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

/* design/hhm_ctrl.sv */
// sequencer: accepts a command item; register writes its slot directly, the others walk
// the slot table one slot per cycle and hand the result to the output register
// depends on hhm_pkg and hhm_if
module hhm_ctrl #(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned IW = 4,
  parameter int unsigned CW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  hhm_in_if.sink          in_if,
  input  hhm_pkg::cfg_t   cfg_i,
  output hhm_pkg::res_t   res_o,
  input  logic            res_ready_i,
  output logic            mem_we_o,
  output logic [IW-1:0]   mem_waddr_o,
  output hhm_pkg::entry_t mem_wdata_o,
  output logic            mem_re_o,
  output logic [IW-1:0]   mem_raddr_o,
  input  hhm_pkg::entry_t mem_rdata_i
);

  hhm_pkg::state_e             state_q, state_d;
  hhm_pkg::op_e                op_q, op_d;
  logic [hhm_pkg::ID_W-1:0]    id_q, id_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic                        pend_q, pend_d;
  logic [IW-1:0]               pidx_q, pidx_d;
  hhm_pkg::res_t               res_q, res_d;

  logic                                 last;
  logic                                 match;
  logic signed [hhm_pkg::HEALTH_W:0]    tick_h;
  logic signed [hhm_pkg::HEALTH_W:0]    hb_h;
  logic signed [hhm_pkg::HEALTH_W:0]    max_h;
  logic signed [hhm_pkg::HEALTH_W-1:0]  tick_new;
  logic signed [hhm_pkg::HEALTH_W-1:0]  hb_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hhm_pkg::ST_IDLE;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    id_q   <= id_d;
    pidx_q <= pidx_d;
    res_q  <= res_d;
  end

  assign last  = (cnt_q == CW'(NUM_SLOTS));
  assign match = (id_q != '0) && (mem_rdata_i.id == id_q);

  assign tick_h   = $signed({mem_rdata_i.health[hhm_pkg::HEALTH_W-1], mem_rdata_i.health})
                    - hhm_pkg::TICK_DEC;
  assign tick_new = (tick_h <= 13'sd0) ? hhm_pkg::HEALTH_NONE
                                       : tick_h[hhm_pkg::HEALTH_W-1:0];
  assign hb_h     = $signed({mem_rdata_i.health[hhm_pkg::HEALTH_W-1], mem_rdata_i.health})
                    + hhm_pkg::HB_INC;
  assign max_h    = $signed({2'b00, cfg_i.health_max});
  assign hb_new   = (hb_h > max_h) ? max_h[hhm_pkg::HEALTH_W-1:0]
                                   : hb_h[hhm_pkg::HEALTH_W-1:0];

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    id_d        = id_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    res_d       = res_q;
    in_if.ready = (state_q == hhm_pkg::ST_IDLE);
    mem_we_o    = 1'b0;
    mem_waddr_o = pidx_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = cnt_q[IW-1:0];
    res_o       = res_q;
    res_o.valid = 1'b0;

    case (state_q)
      hhm_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          op_d   = hhm_pkg::op_e'(in_if.operation);
          id_d   = in_if.device_id;
          res_d  = '0;
          cnt_d  = '0;
          pend_d = 1'b0;
          if (hhm_pkg::op_e'(in_if.operation) == hhm_pkg::OP_REGISTER) begin
            if (int'(in_if.slot) < int'(NUM_SLOTS)) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = IW'(in_if.slot);
              mem_wdata_o.id     = in_if.device_id;
              mem_wdata_o.health = $signed({1'b0, cfg_i.health_default});
              mem_wdata_o.online = 1'b0;
            end
            state_d = hhm_pkg::ST_FIN;
          end else begin
            state_d = hhm_pkg::ST_SCAN;
          end
        end
      end

      hhm_pkg::ST_SCAN: begin
        if (!last) begin
          mem_re_o = 1'b1;
          cnt_d    = cnt_q + CW'(1);
          pidx_d   = cnt_q[IW-1:0];
        end
        pend_d = !last;
        if (pend_q) begin
          case (op_q)
            hhm_pkg::OP_TICK: begin
              if (mem_rdata_i.id != '0) begin
                mem_we_o           = 1'b1;
                mem_wdata_o.health = tick_new;
                mem_wdata_o.online = (tick_new != hhm_pkg::HEALTH_NONE);
              end
              if (last) begin
                state_d = hhm_pkg::ST_FIN;
              end
            end
            hhm_pkg::OP_HEARTBEAT, hhm_pkg::OP_QUERY: begin
              if (match) begin
                res_d.found = 1'b1;
                if (op_q == hhm_pkg::OP_HEARTBEAT) begin
                  mem_we_o           = 1'b1;
                  mem_wdata_o.health = hb_new;
                  res_d.health       = hb_new;
                end else begin
                  res_d.online = mem_rdata_i.online;
                  res_d.health = mem_rdata_i.health;
                end
                state_d = hhm_pkg::ST_FIN;
              end else if (last) begin
                state_d = hhm_pkg::ST_FIN;
              end
            end
            default: begin
              state_d = hhm_pkg::ST_FIN;
            end
          endcase
        end
      end

      hhm_pkg::ST_FIN: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          state_d = hhm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = hhm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/device_heartbeat_health_monitor_unit.sv */
// top level of the device heartbeat health monitor
// holds config registers and the output register, ties sequencer to slot memory
// depends on hhm_pkg, hhm_if, hhm_mem, hhm_ctrl
//
//   channel  direction  handshake          payload
//   in_if    sink       valid/ready        operation, slot, device_id
//   out_if   source     valid/ready        found, online, health
//   cfg      input      cfg_we_i           cfg_idx_i, cfg_data_i
//
// register: the slot is written on accept, then the result goes through FIN to the result register
// tick: one slot read and, if occupied, written back per cycle
// heartbeat/query: the scan stops at the first matching slot, or after the last slot with none
// reset clears the slot table at once through per-slot valid bits
// a new item is taken while the previous result waits in the output register
module device_heartbeat_health_monitor_unit #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  hhm_in_if.sink                          in_if,
  hhm_out_if.source                       out_if,
  input  logic                            cfg_we_i,
  input  logic [hhm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hhm_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);

  hhm_pkg::cfg_t   cfg_q, cfg_d;
  hhm_pkg::res_t   res;
  logic            res_ready;
  logic            out_valid_q;
  logic            out_found_q;
  logic            out_online_q;
  logic signed [hhm_pkg::HEALTH_W-1:0] out_health_q;

  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  hhm_pkg::entry_t mem_wdata;
  logic            mem_re;
  logic [IW-1:0]   mem_raddr;
  hhm_pkg::entry_t mem_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (hhm_pkg::cfg_idx_e'(cfg_idx_i))
        hhm_pkg::CFG_HEALTH_DEFAULT: cfg_d.health_default = cfg_data_i;
        hhm_pkg::CFG_HEALTH_MAX:     cfg_d.health_max     = cfg_data_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.health_default <= hhm_pkg::HEALTH_DEFAULT_RST;
      cfg_q.health_max     <= hhm_pkg::HEALTH_MAX_RST;
      out_valid_q          <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (res.valid && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_found_q  <= res.found;
      out_online_q <= res.online;
      out_health_q <= res.health;
    end
  end

  assign res_ready      = !out_valid_q || out_if.ready;
  assign out_if.valid   = out_valid_q;
  assign out_if.found   = out_found_q;
  assign out_if.online  = out_online_q;
  assign out_if.health  = out_health_q;

  hhm_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .IW        (IW),
    .CW        (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cfg_i       (cfg_q),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  hhm_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .IW        (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
